### rtl/gde_pkg.sv
package gde_pkg;

  localparam int YEAR_W       = 14;
  localparam int YEAR_MAX_DEF = 9999;
  localparam int DIV_W        = 18;
  localparam int DSR_W        = 7;

  localparam logic [2:0] FN_LOAD   = 3'd0;
  localparam logic [2:0] FN_DAYS   = 3'd1;
  localparam logic [2:0] FN_MONTHS = 3'd2;
  localparam logic [2:0] FN_YEARS  = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic REG_EPOCH_YEAR = 1'b0;
  localparam logic REG_EPOCH_WDAY = 1'b1;

  localparam logic [1:0] DV_7   = 2'd0;
  localparam logic [1:0] DV_12  = 2'd1;
  localparam logic [1:0] DV_100 = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic [13:0]        year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic signed [15:0] amount;
  } in_t;

  typedef struct packed {
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday;
    logic [5:0]  week_number;
    logic [1:0]  status;
  } out_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    case (m)
      4'd2: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/gde_div.sv
module gde_div
  import gde_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DIV_W-1:0] a,
  input  logic [1:0]       sel,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic [DSR_W-1:0] rem
);

  localparam int MUL_W  = 19;
  localparam int PROD_W = DIV_W + MUL_W;

  localparam logic [MUL_W-1:0] RECIP_7   = 19'd299594;
  localparam logic [MUL_W-1:0] RECIP_12  = 19'd349526;
  localparam logic [MUL_W-1:0] RECIP_100 = 19'd335545;

  logic [DIV_W-1:0]  a_r;
  logic [1:0]        sel_r;
  logic              mul_r;
  logic              back_r;
  logic              done_r;
  logic [DIV_W-1:0]  quot_r;
  logic [DSR_W-1:0]  rem_r;
  logic [MUL_W-1:0]  recip_c;
  logic [DSR_W-1:0]  dsr_c;
  logic [PROD_W-1:0] prod_c;
  logic [DIV_W-1:0]  quot_c;
  logic [DIV_W-1:0]  back_c;

  assign prod_c = a_r * recip_c;
  assign back_c = a_r - quot_r * {{(DIV_W-DSR_W){1'b0}}, dsr_c};

  always_comb begin
    unique case (sel_r)
      DV_7: begin
        recip_c = RECIP_7;
        dsr_c   = 7'd7;
        quot_c  = DIV_W'(prod_c[PROD_W-1:21]);
      end
      DV_12: begin
        recip_c = RECIP_12;
        dsr_c   = 7'd12;
        quot_c  = DIV_W'(prod_c[PROD_W-1:22]);
      end
      default: begin
        recip_c = RECIP_100;
        dsr_c   = 7'd100;
        quot_c  = DIV_W'(prod_c[PROD_W-1:25]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      back_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= go;
      back_r <= mul_r;
      done_r <= back_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r   <= a;
      sel_r <= sel;
    end
    if (mul_r) begin
      quot_r <= quot_c;
    end
    if (back_r) begin
      rem_r <= back_c[DSR_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

### rtl/gregorian_date_engine.sv
// Gregorian date engine: holds one date and applies one request at a time.
// Input: raise start with a request on in_req while busy is low; the request
// is taken at that edge and busy stays high until the result appears.
// Functions: load, add days, add months, add years, query.
// Output: out_strobe is high for one cycle with the result on out_rsp; the
// receiver cannot stall, so the result must be taken in that cycle.
// Configuration: cfg_we with cfg_idx/cfg_wdata writes epoch year or epoch
// weekday at once; write only while busy is low.
// Sequencing: all division runs through one three-stage reciprocal unit. A
// query takes seven or eight divisions (leap test, four century terms, two
// remainders by 7, and a week-number division unless in week 1) plus one
// step per month before the current one. A valid load adds a leap test;
// adding days adds one plus a step per month walked and a leap test per year
// crossed; adding months adds a division by 12; adding years from Feb 29 adds a leap test.
// Throughput: busy drops in the strobe cycle, so the next request may be
// taken at the edge that ends it.
// Reset (synchronous, rst_n low): date 2001-01-01, epoch year 2001, epoch
// weekday Monday, block idle.
module gregorian_date_engine
  import gde_pkg::*;
#(
  parameter int YEAR_MAX = YEAR_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_req,
  output logic        out_strobe,
  output out_t        out_rsp,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [13:0] cfg_wdata
);

  localparam logic [13:0] YMAX = YEAR_MAX[13:0];

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_LEAP_GO   = 17'h00002,
    S_LEAP_FIN  = 17'h00004,
    S_DIV_WAIT  = 17'h00008,
    S_LOAD_CHK  = 17'h00010,
    S_DAYS      = 17'h00020,
    S_MON_FIN   = 17'h00040,
    S_YEARS_FIN = 17'h00080,
    S_COMMIT    = 17'h00100,
    S_DOY       = 17'h00200,
    S_WK_GO     = 17'h00400,
    S_WK_FIN    = 17'h00800,
    S_MOD_GO    = 17'h01000,
    S_MOD_FIN   = 17'h02000,
    S_W1_FIN    = 17'h04000,
    S_WN_FIN    = 17'h08000,
    S_EMIT      = 17'h10000
  } state_t;

  state_t state_r, div_ret_r, leap_ret_r;

  logic [13:0] cur_y_r, ey_r, y_r;
  logic [3:0]  cur_m_r, m_r, mcnt_r;
  logic [4:0]  cur_d_r;
  logic [2:0]  ew_r, wd_r;
  logic signed [17:0] d_r;
  logic [1:0]  status_r, k_r;
  logic        leap_r;
  logic [8:0]  doy_r;
  logic signed [16:0] acc_r;
  logic [5:0]  week_r;
  logic        out_strobe_r;
  out_t        out_rsp_r;

  logic             div_go_r;
  logic [DIV_W-1:0] div_a_r;
  logic [1:0]       div_sel_r;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  logic [DSR_W-1:0] div_rem;

  gde_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go_r),
    .a    (div_a_r),
    .sel  (div_sel_r),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  logic [4:0]         mlen_c, mprev_c;
  logic signed [17:0] dsum_c;
  logic [19:0]        y12_c;
  logic signed [19:0] tot_c;
  logic signed [16:0] ny_c;
  logic [14:0]        ya_c, ea_c;
  logic signed [16:0] acc_init_c;
  logic signed [16:0] mod_a_c;
  logic [14:0]        wk_op_c;
  logic [3:0]         fs_c;

  assign mlen_c  = month_len(m_r, leap_r);
  assign mprev_c = month_len(m_r - 4'd1, leap_r);
  assign dsum_c  = $signed({13'd0, cur_d_r}) + $signed({{2{in_req.amount[15]}}, in_req.amount});
  assign y12_c   = ({6'd0, cur_y_r} << 3) + ({6'd0, cur_y_r} << 2);
  assign tot_c   = $signed(y12_c) + $signed({16'd0, cur_m_r}) - 20'sd1
                 + $signed({{4{in_req.amount[15]}}, in_req.amount});
  assign ny_c    = $signed({3'd0, cur_y_r}) + $signed({in_req.amount[15], in_req.amount});
  assign ya_c    = {1'b0, y_r} + 15'd3;
  assign ea_c    = {1'b0, ey_r} + 15'd3;
  assign acc_init_c = $signed({14'd0, ew_r}) + $signed({3'd0, y_r}) - $signed({3'd0, ey_r})
                    + $signed({4'd0, ya_c[14:2]}) - $signed({4'd0, ea_c[14:2]})
                    + $signed({8'd0, doy_r});
  assign mod_a_c = acc_r + 17'sd28672;
  assign fs_c    = 4'd7 - {1'b0, div_rem[2:0]};

  always_comb begin
    case (k_r)
      2'd0: wk_op_c = {1'b0, y_r} + 15'd99;
      2'd1: wk_op_c = {1'b0, y_r} + 15'd399;
      2'd2: wk_op_c = {1'b0, ey_r} + 15'd99;
      default: wk_op_c = {1'b0, ey_r} + 15'd399;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_y_r      <= 14'd2001;
      cur_m_r      <= 4'd1;
      cur_d_r      <= 5'd1;
      ey_r         <= 14'd2001;
      ew_r         <= 3'd1;
      div_go_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      div_go_r     <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_EPOCH_YEAR: ey_r <= cfg_wdata;
          REG_EPOCH_WDAY: ew_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            status_r   <= ST_OK;
            y_r        <= cur_y_r;
            m_r        <= cur_m_r;
            d_r        <= $signed({13'd0, cur_d_r});
            leap_ret_r <= S_COMMIT;
            state_r    <= S_COMMIT;
            case (in_req.func)
              FN_LOAD: begin
                if (in_req.year_in == 14'd0 || in_req.year_in > YMAX) begin
                  status_r <= ST_RANGE;
                end else if (in_req.month_in == 4'd0 || in_req.month_in > 4'd12 ||
                             in_req.day_in == 5'd0) begin
                  status_r <= ST_BAD_DATE;
                end else begin
                  y_r        <= in_req.year_in;
                  m_r        <= in_req.month_in;
                  d_r        <= $signed({13'd0, in_req.day_in});
                  leap_ret_r <= S_LOAD_CHK;
                  state_r    <= S_LEAP_GO;
                end
              end
              FN_DAYS: begin
                d_r        <= dsum_c;
                leap_ret_r <= S_DAYS;
                state_r    <= S_LEAP_GO;
              end
              FN_MONTHS: begin
                if (tot_c < 20'sd12) begin
                  status_r <= ST_RANGE;
                end else begin
                  div_a_r   <= tot_c[17:0];
                  div_sel_r <= DV_12;
                  div_go_r  <= 1'b1;
                  div_ret_r <= S_MON_FIN;
                  state_r   <= S_DIV_WAIT;
                end
              end
              FN_YEARS: begin
                if (ny_c < 17'sd1 || ny_c > $signed({3'd0, YMAX})) begin
                  status_r <= ST_RANGE;
                end else begin
                  y_r <= ny_c[13:0];
                  if (cur_m_r == 4'd2 && cur_d_r == 5'd29) begin
                    leap_ret_r <= S_YEARS_FIN;
                    state_r    <= S_LEAP_GO;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_LEAP_GO: begin
          div_a_r   <= {4'd0, y_r};
          div_sel_r <= DV_100;
          div_go_r  <= 1'b1;
          div_ret_r <= S_LEAP_FIN;
          state_r   <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state_r <= div_ret_r;
          end
        end
        S_LEAP_FIN: begin
          leap_r  <= (y_r[1:0] == 2'd0) && (div_rem != '0 || div_quot[1:0] == 2'd0);
          state_r <= leap_ret_r;
        end
        S_LOAD_CHK: begin
          if (d_r > $signed({13'd0, mlen_c})) begin
            status_r <= ST_BAD_DATE;
          end
          state_r <= S_COMMIT;
        end
        S_DAYS: begin
          if (d_r > $signed({13'd0, mlen_c})) begin
            d_r <= d_r - $signed({13'd0, mlen_c});
            if (m_r == 4'd12) begin
              m_r <= 4'd1;
              if (y_r == YMAX) begin
                status_r <= ST_RANGE;
                state_r  <= S_COMMIT;
              end else begin
                y_r     <= y_r + 14'd1;
                state_r <= S_LEAP_GO;
              end
            end else begin
              m_r <= m_r + 4'd1;
            end
          end else if (d_r < 18'sd1) begin
            if (m_r == 4'd1) begin
              if (y_r == 14'd1) begin
                status_r <= ST_RANGE;
                state_r  <= S_COMMIT;
              end else begin
                m_r     <= 4'd12;
                y_r     <= y_r - 14'd1;
                d_r     <= d_r + 18'sd31;
                state_r <= S_LEAP_GO;
              end
            end else begin
              m_r <= m_r - 4'd1;
              d_r <= d_r + $signed({13'd0, mprev_c});
            end
          end else begin
            state_r <= S_COMMIT;
          end
        end
        S_MON_FIN: begin
          if (div_quot > {4'd0, YMAX}) begin
            status_r <= ST_RANGE;
          end else begin
            y_r <= div_quot[13:0];
            m_r <= div_rem[3:0] + 4'd1;
          end
          state_r <= S_COMMIT;
        end
        S_YEARS_FIN: begin
          if (!leap_r) begin
            m_r <= 4'd3;
            d_r <= 18'sd1;
          end
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (status_r == ST_OK) begin
            cur_y_r <= y_r;
            cur_m_r <= m_r;
            cur_d_r <= d_r[4:0];
            doy_r   <= {4'd0, d_r[4:0]} - 9'd1;
          end else begin
            y_r   <= cur_y_r;
            m_r   <= cur_m_r;
            d_r   <= $signed({13'd0, cur_d_r});
            doy_r <= {4'd0, cur_d_r} - 9'd1;
          end
          mcnt_r     <= 4'd1;
          leap_ret_r <= S_DOY;
          state_r    <= S_LEAP_GO;
        end
        S_DOY: begin
          if (mcnt_r < m_r) begin
            doy_r  <= doy_r + {4'd0, month_len(mcnt_r, leap_r)};
            mcnt_r <= mcnt_r + 4'd1;
          end else begin
            acc_r   <= acc_init_c;
            k_r     <= 2'd0;
            state_r <= S_WK_GO;
          end
        end
        S_WK_GO: begin
          div_a_r   <= {3'd0, wk_op_c};
          div_sel_r <= DV_100;
          div_go_r  <= 1'b1;
          div_ret_r <= S_WK_FIN;
          state_r   <= S_DIV_WAIT;
        end
        S_WK_FIN: begin
          case (k_r)
            2'd0: acc_r <= acc_r - $signed({9'd0, div_quot[7:0]});
            2'd1: acc_r <= acc_r + $signed({11'd0, div_quot[7:2]});
            2'd2: acc_r <= acc_r + $signed({9'd0, div_quot[7:0]});
            default: acc_r <= acc_r - $signed({11'd0, div_quot[7:2]});
          endcase
          k_r     <= k_r + 2'd1;
          state_r <= (k_r == 2'd3) ? S_MOD_GO : S_WK_GO;
        end
        S_MOD_GO: begin
          div_a_r   <= {1'b0, mod_a_c};
          div_sel_r <= DV_7;
          div_go_r  <= 1'b1;
          div_ret_r <= S_MOD_FIN;
          state_r   <= S_DIV_WAIT;
        end
        S_MOD_FIN: begin
          wd_r      <= div_rem[2:0];
          div_a_r   <= {15'd0, div_rem[2:0]} + 18'd371 - {9'd0, doy_r};
          div_sel_r <= DV_7;
          div_go_r  <= 1'b1;
          div_ret_r <= S_W1_FIN;
          state_r   <= S_DIV_WAIT;
        end
        S_W1_FIN: begin
          if (doy_r < {5'd0, fs_c}) begin
            week_r  <= 6'd1;
            state_r <= S_EMIT;
          end else begin
            div_a_r   <= {9'd0, doy_r - {5'd0, fs_c}};
            div_sel_r <= DV_7;
            div_go_r  <= 1'b1;
            div_ret_r <= S_WN_FIN;
            state_r   <= S_DIV_WAIT;
          end
        end
        S_WN_FIN: begin
          week_r  <= div_quot[5:0] + 6'd2;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_strobe_r <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT) begin
      out_rsp_r.year_out    <= cur_y_r;
      out_rsp_r.month_out   <= cur_m_r;
      out_rsp_r.day_out     <= cur_d_r;
      out_rsp_r.weekday     <= wd_r;
      out_rsp_r.week_number <= week_r;
      out_rsp_r.status      <= status_r;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

### tb/tb_gregorian_date_engine.sv
module tb_gregorian_date_engine;
  import gde_pkg::*;

  localparam int  YEAR_TOP    = YEAR_MAX_DEF;
  localparam longint CYCLE_CAP = 8000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_req = '0;
  logic        out_strobe;
  out_t        out_rsp;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [13:0] cfg_wdata = '0;

  int     epoch_yr;
  int     epoch_wd;
  int     held_y, held_m, held_d;
  out_t   date_q[$];
  int     err_cnt = 0;
  longint cyc = 0;
  bit     no_gaps = 0;

  gregorian_date_engine uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit leap(int y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic int mlen(int y, int m);
    if (m == 2) return leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic longint days_before(longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic int day_index(int y, int m, int d);
    int n;
    n = d - 1;
    for (int i = 1; i < m; i++) n += mlen(y, i);
    return n;
  endfunction

  function automatic int dow(int y, int m, int d);
    longint t;
    t = epoch_wd + days_before(y) - days_before(epoch_yr) + day_index(y, m, d);
    t = t % 7;
    if (t < 0) t += 7;
    return int'(t);
  endfunction

  function automatic int week_of_year(int y, int m, int d);
    int doy, first_sun;
    doy = day_index(y, m, d);
    first_sun = 7 - dow(y, 1, 1);
    if (doy < first_sun) return 1;
    return (doy - first_sun) / 7 + 2;
  endfunction

  function automatic out_t apply_request(in_t r);
    out_t o;
    logic [1:0] st;
    int y, m, d, amt, total, ny;
    st = ST_OK;
    y = held_y; m = held_m; d = held_d;
    amt = int'(r.amount);
    case (r.func)
      FN_LOAD: begin
        if (r.year_in < 1 || r.year_in > YEAR_TOP) st = ST_RANGE;
        else if (r.month_in < 1 || r.month_in > 12 || r.day_in < 1 ||
                 r.day_in > mlen(r.year_in, r.month_in)) st = ST_BAD_DATE;
        else begin
          y = r.year_in; m = r.month_in; d = r.day_in;
        end
      end
      FN_DAYS: begin
        d += amt;
        while (st == ST_OK && d > mlen(y, m)) begin
          d -= mlen(y, m);
          m++;
          if (m > 12) begin
            m = 1;
            y++;
            if (y > YEAR_TOP) st = ST_RANGE;
          end
        end
        while (st == ST_OK && d < 1) begin
          m--;
          if (m < 1) begin
            m = 12;
            y--;
            if (y < 1) st = ST_RANGE;
          end
          if (st == ST_OK) d += mlen(y, m);
        end
      end
      FN_MONTHS: begin
        total = y * 12 + (m - 1) + amt;
        if (total < 12 || total / 12 > YEAR_TOP) st = ST_RANGE;
        else begin
          y = total / 12; m = total % 12 + 1;
        end
      end
      FN_YEARS: begin
        ny = y + amt;
        if (ny < 1 || ny > YEAR_TOP) st = ST_RANGE;
        else begin
          if (m == 2 && d == 29 && !leap(ny)) begin
            m = 3; d = 1;
          end
          y = ny;
        end
      end
      default: ;
    endcase
    if (st == ST_OK) begin
      held_y = y; held_m = m; held_d = d;
    end
    o.year_out    = 14'(held_y);
    o.month_out   = 4'(held_m);
    o.day_out     = 5'(held_d);
    o.weekday     = 3'(dow(held_y, held_m, held_d));
    o.week_number = 6'(week_of_year(held_y, held_m, held_d));
    o.status      = st;
    return o;
  endfunction

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_strobe) begin
      if (date_q.size() == 0) begin
        $error("unexpected result %p", out_rsp);
        err_cnt++;
      end else begin
        e = date_q.pop_front();
        if (out_rsp.year_out !== e.year_out) begin
          $error("year_out exp %0d got %0d", e.year_out, out_rsp.year_out); err_cnt++;
        end
        if (out_rsp.month_out !== e.month_out) begin
          $error("month_out exp %0d got %0d", e.month_out, out_rsp.month_out); err_cnt++;
        end
        if (out_rsp.day_out !== e.day_out) begin
          $error("day_out exp %0d got %0d", e.day_out, out_rsp.day_out); err_cnt++;
        end
        if (out_rsp.weekday !== e.weekday) begin
          $error("weekday exp %0d got %0d", e.weekday, out_rsp.weekday); err_cnt++;
        end
        if (out_rsp.week_number !== e.week_number) begin
          $error("week_number exp %0d got %0d", e.week_number, out_rsp.week_number);
          err_cnt++;
        end
        if (out_rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_rsp.status); err_cnt++;
        end
      end
    end
  end

  task automatic send_request(in_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk);
    end
    start  = 1'b1;
    in_req = r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    date_q.push_back(apply_request(r));
  endtask

  task automatic send(logic [2:0] f, int y, int m, int d, int amt);
    in_t r;
    r.func = f; r.year_in = 14'(y); r.month_in = 4'(m); r.day_in = 5'(d);
    r.amount = 16'(amt);
    send_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (date_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    drain();
    cfg_we = 1'b1; cfg_idx = idx; cfg_wdata = 14'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_EPOCH_YEAR) epoch_yr = val;
    else epoch_wd = val & 7;
  endtask

  task automatic test_directed();
    send(FN_QUERY, 0, 0, 0, 0);
    send(FN_LOAD, 2024, 2, 29, 0);
    send(FN_YEARS, 0, 0, 0, 1);
    send(FN_LOAD, 2023, 2, 29, 0);
    send(FN_LOAD, 2000, 0, 10, 0);
    send(FN_LOAD, 2000, 13, 10, 0);
    send(FN_LOAD, 2000, 15, 31, 0);
    send(FN_LOAD, 2000, 4, 31, 0);
    send(FN_LOAD, 2000, 4, 0, 0);
    send(FN_LOAD, 0, 5, 5, 0);
    send(FN_LOAD, 16383, 5, 5, 0);
    send(FN_LOAD, 9999, 12, 31, 0);
    send(FN_DAYS, 0, 0, 0, 1);
    send(FN_LOAD, 1, 1, 1, 0);
    send(FN_DAYS, 0, 0, 0, -1);
    send(FN_MONTHS, 0, 0, 0, -1);
    send(FN_LOAD, 2001, 1, 31, 0);
    send(FN_MONTHS, 0, 0, 0, 1);
    send(FN_DAYS, 0, 0, 0, 0);
    send(FN_DAYS, 0, 0, 0, 32767);
    send(FN_DAYS, 0, 0, 0, -32768);
    send(FN_MONTHS, 0, 0, 0, 32767);
    send(FN_YEARS, 0, 0, 0, -32768);
    send(3'(FN_QUERY + 1), 16383, 15, 31, -1);
    send(3'(FN_QUERY + 3), 0, 0, 0, 0);
  endtask

  task automatic random_item();
    int k, amt, y;
    k = $urandom_range(0, 99);
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
    case ($urandom_range(0, 3))
      0: amt = $urandom_range(0, 65535) - 32768;
      1: amt = $urandom_range(0, 800) - 400;
      default: amt = $urandom_range(0, 80) - 40;
    endcase
    if (k < 25) begin
      if ($urandom_range(0, 4) == 0)
        send(FN_LOAD, y, $urandom_range(0, 15), $urandom_range(0, 31), amt);
      else begin
        k = $urandom_range(1, 12);
        send(FN_LOAD, y, k, $urandom_range(1, mlen(y, k)), amt);
      end
    end else if (k < 55) send(FN_DAYS, y, 0, 0, amt);
    else if (k < 75) send(FN_MONTHS, 0, 0, 0, amt);
    else if (k < 92) send(FN_YEARS, 0, 0, 0, amt);
    else send(3'($urandom_range(4, 7)), y, $urandom_range(0, 15), $urandom_range(0, 31), amt);
  endtask

  task automatic test_epochs();
    write_reg(REG_EPOCH_YEAR, 1);
    write_reg(REG_EPOCH_WDAY, 0);
    repeat (20) random_item();
    write_reg(REG_EPOCH_YEAR, 9999);
    write_reg(REG_EPOCH_WDAY, 6);
    repeat (20) random_item();
    write_reg(REG_EPOCH_YEAR, 16383);
    write_reg(REG_EPOCH_WDAY, 7);
    repeat (20) random_item();
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_EPOCH_YEAR, $urandom_range(1, 9999));
      write_reg(REG_EPOCH_WDAY, $urandom_range(0, 7));
      no_gaps = (p % 3 == 1);
      repeat (60) random_item();
    end
    no_gaps = 0;
  endtask

  task automatic test_pressure();
    repeat (10) begin
      random_item();
      drain();
    end
    write_reg(REG_EPOCH_YEAR, 2001);
    write_reg(REG_EPOCH_WDAY, 1);
    repeat (5) random_item();
  endtask

  initial begin
    epoch_yr = 2001; epoch_wd = 1;
    held_y = 2001; held_m = 1; held_d = 1;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_epochs();
    test_random();
    test_pressure();
    drain();
    repeat (200) @(negedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
